FILE: src/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg: shared definitions for the linear interpolation resampler
// Defaults for sample and phase widths, output run limit and register map.
// ----------------------------------------------------------------------------
package lirs_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   // outputs per input beat at most
   localparam int MAX_OUT  = 16;
   localparam int CNT_BITS = $clog2(MAX_OUT);

   // integer bits of the read phase above the fraction
   localparam int PHASE_INT_BITS = 5;

   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_STEP_RATIO    = 1'b0,
      REG_OUTPUT_FORMAT = 1'b1
   } csr_reg_type;

   typedef enum logic {
      FMT_SIGNED        = 1'b0,
      FMT_OFFSET_BINARY = 1'b1
   } out_fmt_type;

endpackage

FILE: src/linear_interp_resampler_core.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_core: streaming linear interpolation resampler
// Interpolates between the previous and current input sample at a Q.FRAC read
// phase, one shared multiplier reused for every output of a run.
// Each result is registered through the multiply, sum and scale states in
// turn; a further result of a run starts once the previous one is taken.
// An input that yields no result is retired in its accept cycle. No new
// input is taken until the last of its N results (N up to 16) is taken.
// Reset: synchronous; step_ratio returns to 1.0, format to signed, phase and
// previous sample to zero. Writing step_ratio also clears phase and sample.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core #(
   parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_in,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [SAMPLE_BITS-1:0]               rsp_sample_out,
   output logic                                 rsp_last_of_run,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lirs_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lirs_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lirs_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import lirs_pkg::*;

   localparam int S     = SAMPLE_BITS;
   localparam int F     = FRAC_BITS;
   localparam int PH_W  = F + PHASE_INT_BITS;
   localparam int PN_W  = PH_W + 1;
   localparam int D_W   = S + 1;
   localparam int W_I   = S + F + 2;
   localparam int W_M   = 2 * S + F + 2;
   localparam int SHIFT = S - 1 + F;

   localparam logic [PH_W-1:0] ONE_P   = PH_W'(1) << F;
   localparam logic [PN_W-1:0] ONE_N   = PN_W'(1) << F;
   localparam logic [W_M-1:0]  DENOM   = W_M'(1) << SHIFT;
   localparam logic [W_M-1:0]  ROUND0  = DENOM - W_M'(1);
   localparam logic [W_M-1:0]  BIAS1   = (DENOM << (S - 1)) - DENOM;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAX_OUT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_SCALE,
      ST_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [PH_W-1:0]          step_ff, step_in;
   out_fmt_type              fmt_ff, fmt_in;
   logic [PH_W-1:0]          phase_ff, phase_in;
   logic signed [S-1:0]      prev_ff, prev_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic signed [S-1:0]      cur_ff, cur_in;
   logic signed [D_W-1:0]    diff_ff, diff_in;
   logic signed [W_I-1:0]    prod_ff, prod_in;
   logic signed [W_I-1:0]    interp_ff, interp_in;
   logic [PN_W-1:0]          pnext_ff, pnext_in;
   logic [S-1:0]             out_ff, out_in;
   logic                     last_ff, last_in;

   logic                     csr_wr;
   csr_reg_type              csr_idx;
   logic signed [F:0]        mul_a;
   logic [W_I-1:0]           prev_shift;
   logic [W_M-1:0]           interp_ext;
   logic [W_M-1:0]           corr;
   logic [W_M-1:0]           scaled;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      case (csr_idx)
         REG_STEP_RATIO:    csr_prdata = CSR_DATA_BITS'(step_ff);
         REG_OUTPUT_FORMAT: csr_prdata = CSR_DATA_BITS'(fmt_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // a register write takes the idle slot, so no input beat is taken with it
   assign req_ready       = (state_ff == ST_IDLE) & ~csr_wr;
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_sample_out  = out_ff;
   assign rsp_last_of_run = last_ff;

   // shared datapath
   assign mul_a      = $signed({1'b0, phase_ff[F-1:0]});
   assign prev_shift = {{2{prev_ff[S-1]}}, prev_ff, {F{1'b0}}};
   assign interp_ext = {{S{interp_ff[W_I-1]}}, interp_ff};
   assign corr       = (fmt_ff == FMT_OFFSET_BINARY) ? BIAS1 :
                       (interp_ff[W_I-1] ? ROUND0 : '0);
   assign scaled     = (interp_ext << (S - 1)) - interp_ext + corr;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      fmt_in    = fmt_ff;
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      cnt_in    = cnt_ff;
      cur_in    = cur_ff;
      diff_in   = diff_ff;
      prod_in   = prod_ff;
      interp_in = interp_ff;
      pnext_in  = pnext_ff;
      out_in    = out_ff;
      last_in   = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_wr) begin
               case (csr_idx)
                  REG_STEP_RATIO: begin
                     step_in  = csr_pwdata[PH_W-1:0];
                     phase_in = '0;
                     prev_in  = '0;
                  end
                  REG_OUTPUT_FORMAT: begin
                     fmt_in = out_fmt_type'(csr_pwdata[0]);
                  end
                  default: begin
                  end
               endcase
            end else if (req_valid) begin
               cur_in  = req_sample_in;
               diff_in = $signed({req_sample_in[S-1], req_sample_in})
                         - $signed({prev_ff[S-1], prev_ff});
               cnt_in  = '0;
               if (|phase_ff[PH_W-1:F]) begin
                  phase_in = phase_ff - ONE_P;
                  prev_in  = req_sample_in;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = mul_a * diff_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            interp_in = $signed(prev_shift) + prod_ff;
            pnext_in  = {1'b0, phase_ff} + {1'b0, step_ff};
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            out_in   = scaled[SHIFT +: S];
            last_in  = (|pnext_ff[PN_W-1:F]) || (cnt_ff == CNT_LAST);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               cnt_in = cnt_ff + CNT_BITS'(1);
               if (last_ff) begin
                  phase_in = (|pnext_ff[PN_W-1:F]) ? PH_W'(pnext_ff - ONE_N) : '0;
                  prev_in  = cur_ff;
                  state_in = ST_IDLE;
               end else begin
                  phase_in = pnext_ff[PH_W-1:0];
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= ONE_P;
         fmt_ff   <= FMT_SIGNED;
         phase_ff <= '0;
         prev_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         fmt_ff   <= fmt_in;
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         cnt_ff   <= cnt_in;
      end
      cur_ff    <= cur_in;
      diff_ff   <= diff_in;
      prod_ff   <= prod_in;
      interp_ff <= interp_in;
      pnext_ff  <= pnext_in;
      out_ff    <= out_in;
      last_ff   <= last_in;
   end

endmodule

FILE: tb/linear_interp_resampler_core_test.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_core_test: self-checking bench for the resampler
// Streams Q1.15 samples through the core under several step ratios and both
// output formats, predicts every interpolated output and its end-of-run flag
// in a local model, and compares each result beat in order. Both channels see
// random idle and stall gaps; configuration is written and read back between
// phases while the stream is drained.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import lirs_pkg::*;

   localparam int SB          = SAMPLE_BITS_DEF;
   localparam int PHASE_BITS  = FRAC_BITS_DEF + PHASE_INT_BITS;
   localparam int INTERP_SHIFT = SB - 1 + FRAC_BITS_DEF;

   localparam longint PHASE_ONE  = longint'(1) << FRAC_BITS_DEF;
   localparam longint INTERP_ONE = longint'(1) << INTERP_SHIFT;
   localparam longint FULL_SCALE = (longint'(1) << (SB - 1)) - 1;

   localparam logic [PHASE_BITS-1:0] STEP_RESET = PHASE_BITS'(65536);
   localparam logic [PHASE_BITS-1:0] STEP_LOW   = PHASE_BITS'(4096);
   localparam logic [PHASE_BITS-1:0] STEP_HIGH  = PHASE_BITS'(1048576);
   localparam logic [PHASE_BITS-1:0] STEP_MAX   = '1;

   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 1_500_000;

   typedef struct packed {
      logic [SB-1:0] sample_out;
      logic          last_of_run;
   } interp_beat_type;

   logic clock;
   logic reset;

   logic                        req_valid;
   logic                        req_ready;
   logic signed [SB-1:0]        req_sample_in;

   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [SB-1:0]               rsp_sample_out;
   logic                        rsp_last_of_run;

   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]    csr_paddr;
   logic [CSR_DATA_BITS-1:0]    csr_pwdata;
   logic [CSR_DATA_BITS-1:0]    csr_prdata;
   logic                        csr_pready;

   // local copy of the block's registers and stream state
   logic [PHASE_BITS-1:0]       step_ratio  = STEP_RESET;
   out_fmt_type                 out_fmt     = FMT_SIGNED;
   logic signed [SB-1:0]        prev_sample = '0;
   logic [PHASE_BITS-1:0]       read_phase  = '0;

   interp_beat_type             pending_interp[$];
   int                          mismatches    = 0;
   int                          cycles        = 0;
   bit                          req_gaps_on   = 1'b1;
   bit                          rsp_stalls_on = 1'b1;

   linear_interp_resampler_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SB-1:0] interp_code(logic signed [SB-1:0] a,
                                                 logic signed [SB-1:0] b,
                                                 longint frac, out_fmt_type fmt);
      longint mix;
      mix = longint'(a) * PHASE_ONE + frac * (longint'(b) - longint'(a));
      if (fmt == FMT_OFFSET_BINARY)
         return SB'(((mix + INTERP_ONE) * FULL_SCALE) >>> INTERP_SHIFT);
      return SB'((mix * FULL_SCALE) / INTERP_ONE);
   endfunction

   // one input beat: emit outputs while the phase is below one, cap at MAX_OUT
   function automatic void resample_step(logic signed [SB-1:0] cur);
      longint          ph;
      int              n;
      interp_beat_type beat;
      ph = longint'(read_phase);
      n  = 0;
      while (ph < PHASE_ONE && n < MAX_OUT) begin
         beat.sample_out  = interp_code(prev_sample, cur, ph, out_fmt);
         beat.last_of_run = (ph + longint'(step_ratio) >= PHASE_ONE) || (n == MAX_OUT - 1);
         pending_interp.insert(pending_interp.size(), beat);
         ph += longint'(step_ratio);
         n++;
      end
      if (ph >= PHASE_ONE) ph -= PHASE_ONE;
      else ph = 0;
      read_phase  = PHASE_BITS'(ph);
      prev_sample = cur;
   endfunction

   always @(posedge clock) begin
      interp_beat_type want;
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_interp.size() == 0) begin
               $display("%0t: unexpected result beat sample_out=%h last=%b",
                        $time, rsp_sample_out, rsp_last_of_run);
               mismatches++;
            end else begin
               want = pending_interp.pop_front();
               if (rsp_sample_out !== want.sample_out) begin
                  $display("%0t: sample_out expected %h actual %h",
                           $time, want.sample_out, rsp_sample_out);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run expected %b actual %b",
                           $time, want.last_of_run, rsp_last_of_run);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            resample_step(req_sample_in);
      end
   end

   initial begin
      int hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 3) == 0)
               hold = pick_gap();
         end
      end
   end

   task automatic send_sample(input logic [SB-1:0] value);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the checker book the beat taken at the last edge
      @(posedge clock);
      while (pending_interp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_check(input csr_reg_type idx, input logic [CSR_DATA_BITS-1:0] want);
      logic [CSR_DATA_BITS-1:0] mask;
      logic [CSR_DATA_BITS-1:0] got;
      mask = (idx == REG_STEP_RATIO) ? CSR_DATA_BITS'(STEP_MAX) : CSR_DATA_BITS'(1);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if ((got & mask) !== (want & mask)) begin
         $display("%0t: register %s expected %h actual %h",
                  $time, idx.name(), want & mask, got & mask);
         mismatches++;
      end
   endtask

   task automatic csr_set(input csr_reg_type idx, input logic [CSR_DATA_BITS-1:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // a rate change restarts the stream
      if (idx == REG_STEP_RATIO) begin
         step_ratio  = value[PHASE_BITS-1:0];
         prev_sample = '0;
         read_phase  = '0;
      end else begin
         out_fmt = out_fmt_type'(value[0]);
      end
      csr_check(idx, value);
   endtask

   function automatic logic [SB-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(SB-1){1'b0}}};
         1: return {1'b0, {(SB-1){1'b1}}};
         2: return SB'($urandom_range(0, 15) - 8);
         default: return SB'($urandom);
      endcase
   endfunction

   function automatic logic [PHASE_BITS-1:0] rand_step();
      case ($urandom_range(0, 9))
         0: return STEP_LOW;
         1: return STEP_HIGH;
         2: return PHASE_BITS'($urandom_range(0, 4095));
         3: return PHASE_BITS'($urandom_range(1048577, 2097151));
         default: return PHASE_BITS'($urandom_range(4096, 262144));
      endcase
   endfunction

   task automatic test_reset_defaults();
      csr_check(REG_STEP_RATIO, CSR_DATA_BITS'(STEP_RESET));
      csr_check(REG_OUTPUT_FORMAT, CSR_DATA_BITS'(FMT_SIGNED));
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hffff);
      send_sample(16'h0001);
   endtask

   task automatic test_offset_binary();
      csr_set(REG_OUTPUT_FORMAT, CSR_DATA_BITS'(FMT_OFFSET_BINARY));
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'h0000);
      send_sample(16'h8000);
   endtask

   task automatic test_step_limits();
      csr_set(REG_STEP_RATIO, CSR_DATA_BITS'(STEP_LOW));
      send_sample(16'h7fff);
      send_sample(16'h8000);
      // step below range: run capped, phase forced to zero
      csr_set(REG_STEP_RATIO, '0);
      send_sample(16'h1234);
      send_sample(16'hedcb);
      // step at the top of the field: mostly inputs with no output
      csr_set(REG_STEP_RATIO, CSR_DATA_BITS'(STEP_MAX));
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'h5555);
   endtask

   task automatic test_rate_restart();
      csr_set(REG_STEP_RATIO, CSR_DATA_BITS'(32768));
      send_sample(16'h4000);
      send_sample(16'hc000);
      csr_set(REG_OUTPUT_FORMAT, CSR_DATA_BITS'(FMT_SIGNED));
      send_sample(16'h2000);
      csr_set(REG_STEP_RATIO, CSR_DATA_BITS'(32768));
      send_sample(16'h7fff);
   endtask

   task automatic test_drain_pause();
      csr_set(REG_STEP_RATIO, CSR_DATA_BITS'(98304));
      send_sample(16'h0100);
      send_sample(16'hff00);
      wait_drained();
      send_sample(16'h2aaa);
      send_sample(16'hd555);
   endtask

   task automatic test_random_streams();
      int n;
      for (int p = 0; p < 8; p++) begin
         rsp_stalls_on = (p % 3) != 2;
         req_gaps_on   = (p % 4) != 3;
         if (p == 0) csr_set(REG_STEP_RATIO, CSR_DATA_BITS'(STEP_LOW));
         else if (p == 1) csr_set(REG_STEP_RATIO, CSR_DATA_BITS'(STEP_HIGH));
         else csr_set(REG_STEP_RATIO, CSR_DATA_BITS'(rand_step()));
         csr_set(REG_OUTPUT_FORMAT, $urandom_range(0, 1));
         n = $urandom_range(40, 60);
         for (int i = 0; i < n; i++) begin
            send_sample(rand_sample());
            if ($urandom_range(0, 63) == 0)
               wait_drained();
         end
      end
      rsp_stalls_on = 1'b1;
      req_gaps_on   = 1'b1;
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_in <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_offset_binary();
      test_step_limits();
      test_rate_restart();
      test_drain_pause();
      test_random_streams();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
src/lirs_pkg.sv
src/linear_interp_resampler_core.sv
tb/linear_interp_resampler_core_test.sv
